### design/rtt_rld_pkg.sv
// Shared types and constants of the RTT estimator and rate-limiter detector.
// It has no dependencies. The divider, window and top level refer to it by scoped names.
package rtt_rld_pkg;

  localparam int unsigned RttW   = 36;
  localparam int unsigned WideW  = 41;
  localparam int unsigned CntW   = 32;
  localparam int unsigned BatchW = 16;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivW   = 64;
  localparam int unsigned QuotW  = 32;
  localparam int unsigned ErrW   = 43;

  localparam int unsigned ScoreWindowDef = 16;

  localparam logic [RttW-1:0] DiscardLimitRst = 36'd10000000000;
  localparam logic [ThrW-1:0] ThresholdRst    = 8'd2;
  localparam logic [ThrW-1:0] MinPushedRst    = 8'd20;
  localparam logic [ThrW-1:0] PushedMax       = 8'd255;

  typedef enum logic [CmdW-1:0] {
    CMD_RTT     = 2'd0,
    CMD_SENT    = 2'd1,
    CMD_ACK     = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DISCARD    = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_MIN_PUSHED = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RTT_ERR,
    ST_RTT_AVG,
    ST_RTT_DEV,
    ST_RTT_ACC,
    ST_DIVIDE,
    ST_WINDOW,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic push;
    logic high;
  } win_req_t;

endpackage

### design/rtt_rld_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
module rtt_rld_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rtt_rld_divider.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
// It depends on rtt_rld_pkg for the dividend and quotient widths.
module rtt_rld_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rtt_rld_pkg::DivW-1:0]      dividend_i,
  input  logic [rtt_rld_pkg::QuotW-1:0]     divisor_i,
  output logic                              done_o,
  output logic [rtt_rld_pkg::QuotW-1:0]     quotient_o
);

  localparam int unsigned DivW  = rtt_rld_pkg::DivW;
  localparam int unsigned QuotW = rtt_rld_pkg::QuotW;
  localparam int unsigned StepW = $clog2(DivW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DivW-1:0]  acc_q, acc_d;
  logic [QuotW-1:0] rem_q, rem_d;
  logic [QuotW-1:0] dsr_q, dsr_d;
  logic [QuotW:0]   rem_sh;
  logic [QuotW:0]   diff;
  logic             fits;

  always_comb begin
    rem_sh = {rem_q, acc_q[DivW-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    fits   = (rem_sh >= {1'b0, dsr_q});
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      acc_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      acc_d  = {acc_q[DivW-2:0], fits};
      rem_d  = fits ? diff[QuotW-1:0] : rem_sh[QuotW-1:0];
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q[QuotW-1:0];

endmodule

### design/rtt_rld_window.sv
// Window of high-score flags with a count of the high flags held and the sticky rate-limiter flag.
// It depends on rtt_rld_pkg and instantiates rtt_rld_ram for the flag store.
module rtt_rld_window #(
  parameter int unsigned ScoreWindow = rtt_rld_pkg::ScoreWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtt_rld_pkg::win_req_t         req_i,
  input  logic [rtt_rld_pkg::ThrW-1:0]  min_pushed_i,
  output logic                          limiter_o
);

  localparam int unsigned ThrW  = rtt_rld_pkg::ThrW;
  localparam int unsigned HeadW = (ScoreWindow > 1) ? $clog2(ScoreWindow) : 1;
  localparam int unsigned FillW = $clog2(ScoreWindow + 1);

  logic [HeadW-1:0] head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] count_q, count_d;
  logic [ThrW-1:0]  pushed_q, pushed_d;
  logic             limiter_q, limiter_d;
  logic [0:0]       old_flag;
  logic             full;
  logic             evicted;

  // A stored flag is only looked at once the window is full, by which time every
  // entry has been written.
  rtt_rld_ram #(
    .Width (1),
    .Depth (ScoreWindow)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (head_q),
    .wdata_i (req_i.high),
    .raddr_i (head_q),
    .rdata_o (old_flag)
  );

  always_comb begin
    full      = (fill_q == FillW'(ScoreWindow));
    evicted   = full & old_flag[0];
    head_d    = head_q;
    fill_d    = fill_q;
    count_d   = count_q;
    pushed_d  = pushed_q;
    limiter_d = limiter_q;
    if (req_i.push) begin
      count_d = count_q - FillW'(evicted) + FillW'(req_i.high);
      if (full) begin
        if (pushed_q != rtt_rld_pkg::PushedMax) begin
          pushed_d = pushed_q + ThrW'(1);
        end
      end else begin
        fill_d = fill_q + FillW'(1);
      end
      if (head_q == HeadW'(ScoreWindow - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + HeadW'(1);
      end
      if ((count_d == '0) && (pushed_d > min_pushed_i)) begin
        limiter_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      count_q   <= '0;
      pushed_q  <= '0;
      limiter_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      pushed_q  <= pushed_d;
      limiter_q <= limiter_d;
    end
  end

  assign limiter_o = limiter_q;

endmodule

### design/rtt_estimator_rate_limit_detector.sv
// Top level of the RTT estimator with rate-limiter detection.
// It depends on rtt_rld_pkg and instantiates rtt_rld_divider and rtt_rld_window.
//
// Events arrive on the input channel (valid/ready) and each produces exactly one
// request on the output channel carrying the estimator state after that event.
// Configuration registers are written through the cfg channel, which is always
// ready and must only be used while the block is idle.
// An RTT sample passes through the four-step average and deviation update before
// its result is loaded; sent and acknowledged events go straight to the result.
// A timeout runs the one-bit-per-cycle divider for 64 steps when a score division
// is needed and skips it when the divisor is zero, then pushes to the window.
// The next event is accepted once the block is back in idle after the previous
// result is loaded. One event is processed at a time.
// The result sits in an output register: a new event is accepted while it waits,
// and a finished event holds in its last state until the receiver takes the
// waiting result.
// Reset clears the estimator state and restores the register defaults; no
// clearing pass is needed.
module rtt_estimator_rate_limit_detector #(
  parameter int unsigned ScoreWindow = rtt_rld_pkg::ScoreWindowDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rtt_rld_pkg::CmdW-1:0]       command_i,
  input  logic [rtt_rld_pkg::RttW-1:0]       rtt_ns_i,
  input  logic [rtt_rld_pkg::BatchW-1:0]     batch_count_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rtt_rld_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rtt_rld_pkg::RttW-1:0]       cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rtt_rld_pkg::RttW-1:0]       rtt_latest_o,
  output logic signed [rtt_rld_pkg::WideW-1:0] rtt_average_scaled_o,
  output logic signed [rtt_rld_pkg::WideW-1:0] rtt_deviation_scaled_o,
  output logic signed [rtt_rld_pkg::WideW-1:0] rtt_minimum_o,
  output logic signed [rtt_rld_pkg::WideW-1:0] rtt_maximum_o,
  output logic signed [rtt_rld_pkg::CntW-1:0]  active_packets_o,
  output logic [rtt_rld_pkg::CntW-1:0]       sent_total_o,
  output logic [rtt_rld_pkg::CntW-1:0]       ack_total_o,
  output logic [rtt_rld_pkg::QuotW-1:0]      drop_score_o,
  output logic                               rate_limiter_o,
  output logic                               sample_discarded_o
);

  localparam int unsigned RttW   = rtt_rld_pkg::RttW;
  localparam int unsigned WideW  = rtt_rld_pkg::WideW;
  localparam int unsigned CntW   = rtt_rld_pkg::CntW;
  localparam int unsigned BatchW = rtt_rld_pkg::BatchW;
  localparam int unsigned ThrW   = rtt_rld_pkg::ThrW;
  localparam int unsigned DivW   = rtt_rld_pkg::DivW;
  localparam int unsigned QuotW  = rtt_rld_pkg::QuotW;
  localparam int unsigned ErrW   = rtt_rld_pkg::ErrW;
  localparam int unsigned DiffW  = WideW + 1;

  rtt_rld_pkg::state_e state_q, state_d;

  logic [RttW-1:0]  limit_q;
  logic [ThrW-1:0]  thr_q;
  logic [ThrW-1:0]  min_pushed_q;

  logic [RttW-1:0]  latest_q, latest_d;
  logic [WideW-1:0] avg_q, avg_d;
  logic [WideW-1:0] dev_q, dev_d;
  logic [WideW-1:0] min_q, min_d;
  logic [WideW-1:0] max_q, max_d;
  logic [CntW-1:0]  active_q, active_d;
  logic [CntW-1:0]  sent_q, sent_d;
  logic [CntW-1:0]  acked_q, acked_d;
  logic [QuotW-1:0] score_q, score_d;
  logic [ErrW-1:0]  err_q, err_d;
  logic             discard_q, discard_d;

  logic             out_valid_q, out_valid_d;
  logic             load_out;
  logic [RttW-1:0]  out_latest_q;
  logic [WideW-1:0] out_avg_q;
  logic [WideW-1:0] out_dev_q;
  logic [WideW-1:0] out_min_q;
  logic [WideW-1:0] out_max_q;
  logic [CntW-1:0]  out_active_q;
  logic [CntW-1:0]  out_sent_q;
  logic [CntW-1:0]  out_acked_q;
  logic [QuotW-1:0] out_score_q;
  logic             out_limiter_q;
  logic             out_discard_q;

  logic [CntW-1:0]  pkts;
  logic [DiffW-1:0] span;
  logic [DivW-1:0]  dividend;
  logic             div_start;
  logic             div_done;
  logic [QuotW-1:0] quotient;
  logic             limiter;
  logic             rtt_above_max;
  logic             rtt_below_min;
  logic [ErrW-1:0]  err_neg;

  rtt_rld_pkg::win_req_t win_req;

  assign pkts     = {{(CntW - BatchW){1'b0}}, batch_count_i} + CntW'(1);
  assign span     = {avg_q[WideW-1], avg_q} - {min_q[WideW-1], min_q};
  assign dividend = {{(DivW - DiffW){span[DiffW-1]}}, span};
  assign err_neg  = ErrW'(0) - err_q;

  assign rtt_above_max = max_q[WideW-1] || ({{(WideW - RttW){1'b0}}, rtt_ns_i} > max_q);
  assign rtt_below_min = (min_q == '1) ||
                         (!min_q[WideW-1] && ({{(WideW - RttW){1'b0}}, rtt_ns_i} < min_q));

  rtt_rld_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (min_q[QuotW-1:0]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  rtt_rld_window #(
    .ScoreWindow (ScoreWindow)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (win_req),
    .min_pushed_i (min_pushed_q),
    .limiter_o    (limiter)
  );

  always_comb begin
    state_d   = state_q;
    latest_d  = latest_q;
    avg_d     = avg_q;
    dev_d     = dev_q;
    min_d     = min_q;
    max_d     = max_q;
    active_d  = active_q;
    sent_d    = sent_q;
    acked_d   = acked_q;
    score_d   = score_q;
    err_d     = err_q;
    discard_d = discard_q;
    div_start = 1'b0;
    win_req   = '0;
    load_out  = 1'b0;
    unique case (state_q)
      rtt_rld_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          discard_d = 1'b0;
          unique case (rtt_rld_pkg::cmd_e'(command_i))
            rtt_rld_pkg::CMD_RTT: begin
              if (rtt_ns_i >= limit_q) begin
                discard_d = 1'b1;
                state_d   = rtt_rld_pkg::ST_FINISH;
              end else begin
                latest_d = rtt_ns_i;
                if (avg_q == '1) begin
                  avg_d = '0;
                end
                if (rtt_above_max) begin
                  max_d = {{(WideW - RttW){1'b0}}, rtt_ns_i};
                end
                if (rtt_below_min) begin
                  min_d = {{(WideW - RttW){1'b0}}, rtt_ns_i};
                end
                state_d = rtt_rld_pkg::ST_RTT_ERR;
              end
            end
            rtt_rld_pkg::CMD_SENT: begin
              active_d = active_q + pkts;
              sent_d   = sent_q + pkts;
              state_d  = rtt_rld_pkg::ST_FINISH;
            end
            rtt_rld_pkg::CMD_ACK: begin
              active_d = active_q - pkts;
              acked_d  = acked_q + pkts;
              state_d  = rtt_rld_pkg::ST_FINISH;
            end
            rtt_rld_pkg::CMD_TIMEOUT: begin
              active_d = active_q - pkts;
              min_d    = avg_q;
              max_d    = avg_q;
              if (min_q[QuotW-1:0] != '0) begin
                div_start = 1'b1;
                state_d   = rtt_rld_pkg::ST_DIVIDE;
              end else begin
                score_d = span[QuotW-1:0];
                state_d = rtt_rld_pkg::ST_WINDOW;
              end
            end
            default: begin
              state_d = rtt_rld_pkg::ST_FINISH;
            end
          endcase
        end
      end
      rtt_rld_pkg::ST_RTT_ERR: begin
        err_d   = {{(ErrW - RttW){1'b0}}, latest_q} -
                  {{(ErrW - WideW + 3){avg_q[WideW-1]}}, avg_q[WideW-1:3]};
        state_d = rtt_rld_pkg::ST_RTT_AVG;
      end
      rtt_rld_pkg::ST_RTT_AVG: begin
        avg_d   = avg_q + err_q[WideW-1:0];
        err_d   = err_q[ErrW-1] ? err_neg : err_q;
        state_d = rtt_rld_pkg::ST_RTT_DEV;
      end
      rtt_rld_pkg::ST_RTT_DEV: begin
        err_d   = err_q - {{(ErrW - WideW + 2){dev_q[WideW-1]}}, dev_q[WideW-1:2]};
        state_d = rtt_rld_pkg::ST_RTT_ACC;
      end
      rtt_rld_pkg::ST_RTT_ACC: begin
        dev_d   = dev_q + err_q[WideW-1:0];
        state_d = rtt_rld_pkg::ST_FINISH;
      end
      rtt_rld_pkg::ST_DIVIDE: begin
        if (div_done) begin
          score_d = quotient;
          state_d = rtt_rld_pkg::ST_WINDOW;
        end
      end
      rtt_rld_pkg::ST_WINDOW: begin
        win_req.push = 1'b1;
        win_req.high = (score_q >= {{(QuotW - ThrW){1'b0}}, thr_q});
        state_d      = rtt_rld_pkg::ST_FINISH;
      end
      rtt_rld_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = rtt_rld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rtt_rld_pkg::ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rtt_rld_pkg::ST_IDLE;
      limit_q      <= rtt_rld_pkg::DiscardLimitRst;
      thr_q        <= rtt_rld_pkg::ThresholdRst;
      min_pushed_q <= rtt_rld_pkg::MinPushedRst;
      latest_q     <= '0;
      avg_q        <= '1;
      dev_q        <= '0;
      min_q        <= '1;
      max_q        <= '0;
      active_q     <= '0;
      sent_q       <= '0;
      acked_q      <= '0;
      score_q      <= '0;
      discard_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      latest_q    <= latest_d;
      avg_q       <= avg_d;
      dev_q       <= dev_d;
      min_q       <= min_d;
      max_q       <= max_d;
      active_q    <= active_d;
      sent_q      <= sent_d;
      acked_q     <= acked_d;
      score_q     <= score_d;
      discard_q   <= discard_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (rtt_rld_pkg::cfg_reg_e'(cfg_index_i))
          rtt_rld_pkg::REG_DISCARD:    limit_q      <= cfg_data_i;
          rtt_rld_pkg::REG_THRESHOLD:  thr_q        <= cfg_data_i[ThrW-1:0];
          rtt_rld_pkg::REG_MIN_PUSHED: min_pushed_q <= cfg_data_i[ThrW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    if (load_out) begin
      out_latest_q  <= latest_q;
      out_avg_q     <= avg_q;
      out_dev_q     <= dev_q;
      out_min_q     <= min_q;
      out_max_q     <= max_q;
      out_active_q  <= active_q;
      out_sent_q    <= sent_q;
      out_acked_q   <= acked_q;
      out_score_q   <= score_q;
      out_limiter_q <= limiter;
      out_discard_q <= discard_q;
    end
  end

  assign in_ready_o             = (state_q == rtt_rld_pkg::ST_IDLE);
  assign cfg_ready_o            = 1'b1;
  assign out_valid_o            = out_valid_q;
  assign rtt_latest_o           = out_latest_q;
  assign rtt_average_scaled_o   = $signed(out_avg_q);
  assign rtt_deviation_scaled_o = $signed(out_dev_q);
  assign rtt_minimum_o          = $signed(out_min_q);
  assign rtt_maximum_o          = $signed(out_max_q);
  assign active_packets_o       = $signed(out_active_q);
  assign sent_total_o           = out_sent_q;
  assign ack_total_o            = out_acked_q;
  assign drop_score_o           = out_score_q;
  assign rate_limiter_o         = out_limiter_q;
  assign sample_discarded_o     = out_discard_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for the RTT estimator and rate-limiter detector.
// It depends on rtt_rld_pkg and rtt_estimator_rate_limit_detector. Every accepted
// event is run through a local estimator model and the next result request is compared.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rtt_rld_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned TailCycles = 80;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned NumRows    = 20;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam logic [WideW-1:0]   NoRtt    = '1;
  localparam logic [RttW-1:0]    RttMax   = '1;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic [RttW-1:0]  latest;
    logic [WideW-1:0] average;
    logic [WideW-1:0] deviation;
    logic [WideW-1:0] rtt_min;
    logic [WideW-1:0] rtt_max;
    logic [CntW-1:0]  active;
    logic [CntW-1:0]  sent;
    logic [CntW-1:0]  acked;
    logic [QuotW-1:0] score;
    logic             limiter;
    logic             discarded;
  } estimate_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [RttW-1:0]   rtt;
    logic [BatchW-1:0] batch;
    logic              typed;
    estimate_t         want;
  } event_row_t;

  typedef struct packed {
    logic [RttW-1:0] discard;
    logic [ThrW-1:0] threshold;
    logic [ThrW-1:0] min_pushed;
    int unsigned     items;
    int unsigned     pause_pct;
  } phase_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i = '0;
  logic [RttW-1:0]     rtt_ns_i = '0;
  logic [BatchW-1:0]   batch_count_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [RttW-1:0]     cfg_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [RttW-1:0]     rtt_latest_o;
  logic signed [WideW-1:0] rtt_average_scaled_o;
  logic signed [WideW-1:0] rtt_deviation_scaled_o;
  logic signed [WideW-1:0] rtt_minimum_o;
  logic signed [WideW-1:0] rtt_maximum_o;
  logic signed [CntW-1:0]  active_packets_o;
  logic [CntW-1:0]     sent_total_o;
  logic [CntW-1:0]     ack_total_o;
  logic [QuotW-1:0]    drop_score_o;
  logic                rate_limiter_o;
  logic                sample_discarded_o;

  rtt_estimator_rate_limit_detector u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .command_i              (command_i),
    .rtt_ns_i               (rtt_ns_i),
    .batch_count_i          (batch_count_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .rtt_latest_o           (rtt_latest_o),
    .rtt_average_scaled_o   (rtt_average_scaled_o),
    .rtt_deviation_scaled_o (rtt_deviation_scaled_o),
    .rtt_minimum_o          (rtt_minimum_o),
    .rtt_maximum_o          (rtt_maximum_o),
    .active_packets_o       (active_packets_o),
    .sent_total_o           (sent_total_o),
    .ack_total_o            (ack_total_o),
    .drop_score_o           (drop_score_o),
    .rate_limiter_o         (rate_limiter_o),
    .sample_discarded_o     (sample_discarded_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the estimator state and its registers.
  logic [RttW-1:0]  discard_limit = DiscardLimitRst;
  logic [ThrW-1:0]  score_threshold = ThresholdRst;
  logic [ThrW-1:0]  min_pushed = MinPushedRst;
  logic [RttW-1:0]  last_rtt = '0;
  s64_t             avg_s = -1;
  s64_t             dev_s = 0;
  s64_t             min_s = -1;
  s64_t             max_s = 0;
  logic [CntW-1:0]  active_n = '0;
  logic [CntW-1:0]  sent_n = '0;
  logic [CntW-1:0]  acked_n = '0;
  logic [QuotW-1:0] score_n = '0;
  logic             high_flags [ScoreWindowDef];
  int unsigned      fill = 0;
  int unsigned      head = 0;
  logic [ThrW-1:0]  pushed = '0;
  logic             limiter = 1'b0;

  estimate_t   pending_estimates [$];
  estimate_t   oldest;
  estimate_t   observed;
  int unsigned mismatches = 0;
  int unsigned pause_pct = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    foreach (high_flags[i]) high_flags[i] = 1'b0;
  end

  function automatic s64_t wrap41(s64_t x);
    logic signed [WideW-1:0] v;
    v = x[WideW-1:0];
    return v;
  endfunction

  function automatic estimate_t estimate_after_event(cmd_e cmd, logic [RttW-1:0] rtt,
                                                     logic [BatchW-1:0] batch);
    estimate_t   r;
    logic [CntW-1:0] n;
    s64_t        sample;
    s64_t        err;
    logic [63:0] quotient;
    logic [63:0] divisor;
    logic        any_high;
    n = {16'd0, batch} + 32'd1;
    r.discarded = 1'b0;
    case (cmd)
      CMD_RTT: begin
        if (rtt >= discard_limit) begin
          r.discarded = 1'b1;
        end else begin
          sample = {28'd0, rtt};
          last_rtt = rtt;
          if (avg_s == -1) avg_s = 0;
          if (max_s == -1 || sample > max_s) max_s = sample;
          if (min_s == -1 || sample < min_s) min_s = sample;
          err = sample - (avg_s >>> 3);
          avg_s = wrap41(avg_s + err);
          if (err < 0) err = -err;
          err = err - (dev_s >>> 2);
          dev_s = wrap41(dev_s + err);
        end
      end
      CMD_SENT: begin
        active_n = active_n + n;
        sent_n = sent_n + n;
      end
      CMD_ACK: begin
        active_n = active_n - n;
        acked_n = acked_n + n;
      end
      default: begin
        active_n = active_n - n;
        quotient = avg_s - min_s;
        divisor = {32'd0, min_s[31:0]};
        if (min_s != 0 && divisor != 0) quotient = quotient / divisor;
        score_n = quotient[QuotW-1:0];
        if (fill >= ScoreWindowDef) begin
          if (pushed < PushedMax) pushed = pushed + 8'd1;
        end else begin
          fill = fill + 1;
        end
        high_flags[head] = (score_n >= {24'd0, score_threshold});
        head = (head + 1) % ScoreWindowDef;
        any_high = 1'b0;
        for (int i = 0; i < ScoreWindowDef && i < fill; i++) begin
          if (high_flags[i]) any_high = 1'b1;
        end
        if (!any_high && pushed > min_pushed) limiter = 1'b1;
        min_s = avg_s;
        max_s = avg_s;
      end
    endcase
    r.latest = last_rtt;
    r.average = avg_s[WideW-1:0];
    r.deviation = dev_s[WideW-1:0];
    r.rtt_min = min_s[WideW-1:0];
    r.rtt_max = max_s[WideW-1:0];
    r.active = active_n;
    r.sent = sent_n;
    r.acked = acked_n;
    r.score = score_n;
    r.limiter = limiter;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Must be called in the time step of a rising edge.
  task automatic send_event(cmd_e cmd, logic [RttW-1:0] rtt, logic [BatchW-1:0] batch,
                            logic typed, estimate_t want);
    estimate_t predicted;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    rtt_ns_i <= rtt;
    batch_count_i <= batch;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = estimate_after_event(cmd, rtt, batch);
    pending_estimates.push_back(typed ? want : predicted);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] index, logic [RttW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_DISCARD:    discard_limit = data;
      REG_THRESHOLD:  score_threshold = data[ThrW-1:0];
      REG_MIN_PUSHED: min_pushed = data[ThrW-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed = {rtt_latest_o, rtt_average_scaled_o, rtt_deviation_scaled_o, rtt_minimum_o,
                  rtt_maximum_o, active_packets_o, sent_total_o, ack_total_o, drop_score_o,
                  rate_limiter_o, sample_discarded_o};
      if (pending_estimates.size() == 0) begin
        $display("%0t: unexpected result request, got %0h", $time, observed);
        mismatches++;
      end else begin
        oldest = pending_estimates.pop_front();
        check_field("rtt_latest", oldest.latest, observed.latest);
        check_field("rtt_average_scaled", oldest.average, observed.average);
        check_field("rtt_deviation_scaled", oldest.deviation, observed.deviation);
        check_field("rtt_minimum", oldest.rtt_min, observed.rtt_min);
        check_field("rtt_maximum", oldest.rtt_max, observed.rtt_max);
        check_field("active_packets", oldest.active, observed.active);
        check_field("sent_total", oldest.sent, observed.sent);
        check_field("ack_total", oldest.acked, observed.acked);
        check_field("drop_score", oldest.score, observed.score);
        check_field("rate_limiter", oldest.limiter, observed.limiter);
        check_field("sample_discarded", oldest.discarded, observed.discarded);
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < pause_pct) begin
      stall_left <= $urandom_range(0, 17);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    event_row_t        rows [NumRows];
    phase_t            phases [NumPhases];
    cmd_e              cmd;
    logic [RttW-1:0]   sample;
    logic [RttW-1:0]   base;
    logic [RttW-1:0]   noise;
    logic [BatchW-1:0] batch;
    int unsigned       timeout_run;
    int unsigned       pick;

    rows[0]  = '{CMD_TIMEOUT, 36'd0, 16'd0, 1'b1,
                 '{36'd0, NoRtt, 41'd0, NoRtt, NoRtt, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                   1'b0, 1'b0}};
    rows[1]  = '{CMD_RTT, 36'd10000000000, 16'hFFFF, 1'b1,
                 '{36'd0, NoRtt, 41'd0, NoRtt, NoRtt, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                   1'b0, 1'b1}};
    rows[2]  = '{CMD_RTT, RttMax, 16'd0, 1'b1,
                 '{36'd0, NoRtt, 41'd0, NoRtt, NoRtt, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                   1'b0, 1'b1}};
    rows[3]  = '{CMD_RTT, 36'd0, 16'd0, 1'b1,
                 '{36'd0, 41'd0, 41'd0, 41'd0, 41'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
                   1'b0, 1'b0}};
    rows[4]  = '{CMD_TIMEOUT, 36'd0, 16'hFFFF, 1'b1,
                 '{36'd0, 41'd0, 41'd0, 41'd0, 41'd0, 32'hFFFE_FFFF, 32'd0, 32'd0, 32'd0,
                   1'b0, 1'b0}};
    rows[5]  = '{CMD_SENT, RttMax, 16'hFFFF, 1'b1,
                 '{36'd0, 41'd0, 41'd0, 41'd0, 41'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0,
                   32'd0, 1'b0, 1'b0}};
    rows[6]  = '{CMD_ACK, 36'd0, 16'd0, 1'b1,
                 '{36'd0, 41'd0, 41'd0, 41'd0, 41'd0, 32'hFFFF_FFFE, 32'h0001_0000, 32'd1,
                   32'd0, 1'b0, 1'b0}};
    rows[7]  = '{CMD_RTT, 36'd9999999999, 16'd3, 1'b0, '0};
    rows[8]  = '{CMD_TIMEOUT, 36'd0, 16'd0, 1'b0, '0};
    rows[9]  = '{CMD_RTT, 36'd1, 16'd7, 1'b0, '0};
    rows[10] = '{CMD_TIMEOUT, 36'd0, 16'd1, 1'b0, '0};
    rows[11] = '{CMD_RTT, 36'd8589934592, 16'd0, 1'b0, '0};
    rows[12] = '{CMD_TIMEOUT, RttMax, 16'd2, 1'b0, '0};
    rows[13] = '{CMD_RTT, 36'd5000, 16'd0, 1'b0, '0};
    rows[14] = '{CMD_RTT, 36'd5100, 16'd0, 1'b0, '0};
    rows[15] = '{CMD_RTT, 36'd4900, 16'd0, 1'b0, '0};
    rows[16] = '{CMD_TIMEOUT, 36'd0, 16'd0, 1'b0, '0};
    rows[17] = '{CMD_TIMEOUT, 36'd0, 16'd0, 1'b0, '0};
    rows[18] = '{CMD_SENT, 36'hA_5A5A_5A5A, 16'd1234, 1'b0, '0};
    rows[19] = '{CMD_ACK, 36'h5_A5A5_A5A5, 16'd1233, 1'b0, '0};

    phases[0] = '{RttMax, 8'd0, 8'd255, 222, 20};
    phases[1] = '{36'd12000, 8'd255, 8'd255, 222, 0};
    phases[2] = '{36'd0, 8'd1, 8'd255, 222, 30};
    phases[3] = '{DiscardLimitRst, 8'd8, 8'd255, 222, 10};
    phases[4] = '{{4'($urandom_range(0, 15)), 32'($urandom)}, 8'($urandom_range(1, 16)),
                  8'($urandom_range(16, 60)), 222, 25};
    phases[5] = '{RttMax, 8'd10, 8'd0, 222, 0};

    base = 36'd5000;
    timeout_run = 0;
    pause_pct = 30;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NumRows; k++) begin
      if ($urandom_range(0, 99) < pause_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      send_event(rows[k].cmd, rows[k].rtt, rows[k].batch, rows[k].typed, rows[k].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      in_valid_i <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clk_i);
      noise = {4'($urandom_range(0, 15)), 32'($urandom)};
      if (p == 0) write_register(RegSpare, noise);
      write_register(REG_DISCARD, phases[p].discard);
      write_register(REG_THRESHOLD, {noise[RttW-1:ThrW], phases[p].threshold});
      write_register(REG_MIN_PUSHED, {~noise[RttW-1:ThrW], phases[p].min_pushed});
      cfg_valid_i <= 1'b0;
      pause_pct = phases[p].pause_pct;

      for (int k = 0; k < phases[p].items; k++) begin
        if ($urandom_range(0, 99) < pause_pct) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk_i);
        end
        if ($urandom_range(0, 99) < 3) begin
          base = {4'($urandom_range(0, 15)), 32'($urandom)} >> $urandom_range(8, 35);
        end
        sample = {4'($urandom_range(0, 15)), 32'($urandom)};
        pick = $urandom_range(0, 99);
        if (timeout_run != 0) begin
          cmd = CMD_TIMEOUT;
          timeout_run--;
        end else if (pick < 45) begin
          cmd = CMD_RTT;
          case ($urandom_range(0, 9))
            0: ;
            1: sample = discard_limit + 36'($urandom_range(0, 2)) - 36'd1;
            2: sample = 36'($urandom_range(0, 3));
            default: sample = base - (base >> 4) + (base >> 11) * 36'($urandom_range(0, 255)) +
                              36'($urandom_range(0, 7));
          endcase
        end else if (pick < 62) begin
          cmd = CMD_SENT;
        end else if (pick < 79) begin
          cmd = CMD_ACK;
        end else begin
          cmd = CMD_TIMEOUT;
          if ($urandom_range(0, 3) == 0) timeout_run = $urandom_range(1, 24);
        end
        case ($urandom_range(0, 7))
          0: batch = '0;
          1: batch = '1;
          2: batch = 16'($urandom);
          default: batch = 16'($urandom_range(0, 63));
        endcase
        send_event(cmd, sample, batch, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
